[design/rtp_icn_pkg.sv]
// Shared types and constants for the RTP ingest classifier and NACK generator.
package rtp_icn_pkg;

   // Default cap on NACKs sent for one sequence gap
   localparam int unsigned MAX_NACK_RUN_DEF = 63;

   // Header length limits in bytes
   localparam logic [10:0] MIN_RTP_LEN = 11'd12;
   localparam logic [10:0] REPORT_LEN  = 11'd28;

   // Configuration port geometry
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEPT_ADDRESS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_TYPE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIDEO_TYPE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_SOURCE_ID = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VIDEO_SOURCE_ID = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PING_TYPE       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_TYPE     = 3'd6;

   // Register reset values
   localparam logic [6:0] AUDIO_TYPE_RST  = 7'd97;
   localparam logic [6:0] VIDEO_TYPE_RST  = 7'd96;
   localparam logic [7:0] PING_TYPE_RST   = 8'd250;
   localparam logic [7:0] REPORT_TYPE_RST = 8'd200;

   // Result classification codes
   typedef enum logic [2:0] {
      K_BADSRC  = 3'd0,
      K_SHORT   = 3'd1,
      K_AUDIO   = 3'd2,
      K_VIDEO   = 3'd3,
      K_PING    = 3'd4,
      K_REPORT  = 3'd5,
      K_UNKNOWN = 3'd6,
      K_NACK    = 3'd7
   } kind_type;

   // Media stream slots in the sequence tracker
   localparam logic STREAM_AUDIO = 1'b0;
   localparam logic STREAM_VIDEO = 1'b1;

endpackage

[design/rtp_icn_if.sv]
// Handshake channel interfaces for the header input and the result output.
interface rtp_icn_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] source_addr;
   logic [10:0] packet_length;
   logic [6:0]  payload_type;
   logic        marker;
   logic [15:0] sequence_req;

   modport source (output valid, source_addr, packet_length, payload_type, marker,
                   sequence_req, input ready);
   modport sink   (input valid, source_addr, packet_length, payload_type, marker,
                   sequence_req, output ready);
endinterface

interface rtp_icn_rsp_if;
   logic                  valid;
   logic                  ready;
   rtp_icn_pkg::kind_type kind;
   logic [15:0]           nack_sequence;
   logic [31:0]           nack_ssrc;
   logic                  last;
   logic                  length_bad;
   logic [31:0]           received_count;
   logic [31:0]           lost_count;
   logic [31:0]           nacked_count;

   modport source (output valid, kind, nack_sequence, nack_ssrc, last, length_bad,
                   received_count, lost_count, nacked_count, input ready);
   modport sink   (input valid, kind, nack_sequence, nack_ssrc, last, length_bad,
                   received_count, lost_count, nacked_count, output ready);
endinterface

[design/rtp_ingest_classify_and_nack.sv]
// Top level: RTP header classifier with per-stream sequence tracking and NACK generation.
//
//  Channel   Dir  Handshake      Carries
//  req_bus   in   valid/ready    one RTP header transaction per datagram
//  rsp_bus   out  valid/ready    classification, then NACKs, with running totals
//  csr_*     in   write enable   register index and write data, no read-back
//
// Path per header: rejected and non-media headers go from the difference step to
// emit; a media packet that is no forward step (first, duplicate or older) also
// passes the received-total step; a forward step whose gap yields n NACKs (n may
// be 0) also passes the lost and NACKed steps. The single 32-bit adder is stepped
// through the sequence difference, the three totals and each NACK number in turn.
// Reset (synchronous, active high) clears the tracker and totals and sets the registers to their reset values.
// A stalled result channel holds the sequencer in its emit state; the input
// is taken only in the idle state, also while the last result still waits.
module rtp_ingest_classify_and_nack #(
   parameter int unsigned MAX_NACK_RUN = rtp_icn_pkg::MAX_NACK_RUN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   rtp_icn_req_if.sink                         req_bus,
   rtp_icn_rsp_if.source                       rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [rtp_icn_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rtp_icn_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int unsigned CNT_W     = $clog2(MAX_NACK_RUN + 1);
   localparam logic [15:0] RUN_LIMIT = 16'(MAX_NACK_RUN);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_NACK_RUN);
   localparam logic [CNT_W-1:0] CNT_ZERO = '0;
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DIST   = 6'b000010,
      S_RECV   = 6'b000100,
      S_LOST   = 6'b001000,
      S_NACKED = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   // Configuration registers
   logic [31:0] accept_address_ff;
   logic [6:0]  audio_type_ff;
   logic [6:0]  video_type_ff;
   logic [31:0] audio_source_id_ff;
   logic [31:0] video_source_id_ff;
   logic [7:0]  ping_type_ff;
   logic [7:0]  report_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_address_ff  <= '0;
         audio_type_ff      <= rtp_icn_pkg::AUDIO_TYPE_RST;
         video_type_ff      <= rtp_icn_pkg::VIDEO_TYPE_RST;
         audio_source_id_ff <= '0;
         video_source_id_ff <= '0;
         ping_type_ff       <= rtp_icn_pkg::PING_TYPE_RST;
         report_type_ff     <= rtp_icn_pkg::REPORT_TYPE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rtp_icn_pkg::CSR_ACCEPT_ADDRESS:  accept_address_ff  <= csr_write_data;
            rtp_icn_pkg::CSR_AUDIO_TYPE:      audio_type_ff      <= csr_write_data[6:0];
            rtp_icn_pkg::CSR_VIDEO_TYPE:      video_type_ff      <= csr_write_data[6:0];
            rtp_icn_pkg::CSR_AUDIO_SOURCE_ID: audio_source_id_ff <= csr_write_data;
            rtp_icn_pkg::CSR_VIDEO_SOURCE_ID: video_source_id_ff <= csr_write_data;
            rtp_icn_pkg::CSR_PING_TYPE:       ping_type_ff       <= csr_write_data[7:0];
            rtp_icn_pkg::CSR_REPORT_TYPE:     report_type_ff     <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // Sequencer and working registers
   state_type             state_ff, state_in;
   logic [31:0]           src_ff;
   logic [10:0]           len_ff;
   logic [6:0]            pt_ff;
   logic                  mk_ff;
   logic [15:0]           seq_ff;
   rtp_icn_pkg::kind_type kind_ff, kind_in;
   logic                  len_bad_ff, len_bad_in;
   logic                  stream_ff;
   logic                  advance_ff, advance_in;
   logic [15:0]           gap_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [15:0]           nack_seq_ff;
   logic                  first_ff;

   // Sequence tracker and totals
   logic [15:0] latest_seq_ff [2];
   logic [1:0]  seq_seen_ff;
   logic [31:0] received_ff;
   logic [31:0] lost_ff;
   logic [31:0] nacked_ff;

   // Result register
   logic                  rsp_valid_ff;
   rtp_icn_pkg::kind_type rsp_kind_ff;
   logic [15:0]           rsp_nack_seq_ff;
   logic [31:0]           rsp_ssrc_ff;
   logic                  rsp_last_ff;
   logic                  rsp_len_bad_ff;
   logic [31:0]           rsp_received_ff;
   logic [31:0]           rsp_lost_ff;
   logic [31:0]           rsp_nacked_ff;

   logic req_fire;
   logic slot_free;
   logic rsp_load;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_load      = (state_ff == S_EMIT) && slot_free;

   // Classification of the latched header
   logic       is_video;
   logic       is_audio;
   logic       is_media;
   logic [7:0] full_type;
   logic       dist_stream;

   assign is_video    = (pt_ff == video_type_ff);
   assign is_audio    = (pt_ff == audio_type_ff);
   assign full_type   = {mk_ff, pt_ff};
   assign dist_stream = is_video ? rtp_icn_pkg::STREAM_VIDEO : rtp_icn_pkg::STREAM_AUDIO;

   // Shared adder: operands steered by the sequencer state
   logic [31:0] alu_a;
   logic [31:0] alu_b;
   logic [31:0] alu_sum;

   always_comb begin
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff)
         S_DIST: begin
            // seq - prev - 1 is the gap; ones' complement without carry-in
            alu_a = {16'b0, seq_ff};
            alu_b = {16'hFFFF, ~latest_seq_ff[dist_stream]};
         end
         S_RECV: begin
            alu_a = received_ff;
            alu_b = 32'd1;
         end
         S_LOST: begin
            alu_a = lost_ff;
            alu_b = {16'b0, gap_ff};
         end
         S_NACKED: begin
            alu_a = nacked_ff;
            alu_b = 32'(cnt_ff);
         end
         S_EMIT: begin
            alu_a = {16'b0, nack_seq_ff};
            alu_b = 32'd1;
         end
         S_IDLE: ;
         default: ;
      endcase
      alu_sum = alu_a + alu_b;
   end

   logic [15:0] gap_now;

   assign gap_now = alu_sum[15:0];

   always_comb begin
      kind_in    = rtp_icn_pkg::K_UNKNOWN;
      len_bad_in = 1'b0;
      is_media   = 1'b0;
      priority if (src_ff != accept_address_ff) begin
         kind_in = rtp_icn_pkg::K_BADSRC;
      end else if (len_ff < rtp_icn_pkg::MIN_RTP_LEN) begin
         kind_in = rtp_icn_pkg::K_SHORT;
      end else if (is_video) begin
         kind_in  = rtp_icn_pkg::K_VIDEO;
         is_media = 1'b1;
      end else if (is_audio) begin
         kind_in  = rtp_icn_pkg::K_AUDIO;
         is_media = 1'b1;
      end else if (full_type == ping_type_ff) begin
         kind_in = rtp_icn_pkg::K_PING;
      end else if (full_type == report_type_ff) begin
         kind_in    = rtp_icn_pkg::K_REPORT;
         len_bad_in = (len_ff != rtp_icn_pkg::REPORT_LEN);
      end else begin
         kind_in = rtp_icn_pkg::K_UNKNOWN;
      end
   end

   // Forward jump: distance 1..32767, i.e. gap below 0x7FFF
   always_comb begin
      advance_in = is_media && seq_seen_ff[dist_stream] && (gap_now < 16'h7FFF);
      cnt_in     = CNT_ZERO;
      if (advance_in) begin
         cnt_in = (gap_now < RUN_LIMIT) ? gap_now[CNT_W-1:0] : CNT_MAX;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_fire) state_in = S_DIST;
         S_DIST:   state_in = is_media ? S_RECV : S_EMIT;
         S_RECV:   state_in = advance_ff ? S_LOST : S_EMIT;
         S_LOST:   state_in = S_NACKED;
         S_NACKED: state_in = S_EMIT;
         S_EMIT: begin
            if (slot_free && cnt_ff == CNT_ZERO) state_in = S_IDLE;
            else if (slot_free && !first_ff && cnt_ff == CNT_ONE) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Header latch
   always_ff @(posedge clock) begin
      if (req_fire) begin
         src_ff <= req_bus.source_addr;
         len_ff <= req_bus.packet_length;
         pt_ff  <= req_bus.payload_type;
         mk_ff  <= req_bus.marker;
         seq_ff <= req_bus.sequence_req;
      end
   end

   // Per-item working state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff   <= 1'b0;
         cnt_ff     <= CNT_ZERO;
         advance_ff <= 1'b0;
      end else if (state_ff == S_DIST) begin
         kind_ff     <= kind_in;
         len_bad_ff  <= len_bad_in;
         stream_ff   <= dist_stream;
         advance_ff  <= advance_in;
         gap_ff      <= gap_now;
         cnt_ff      <= cnt_in;
         nack_seq_ff <= latest_seq_ff[dist_stream];
         first_ff    <= 1'b1;
      end else if (rsp_load) begin
         first_ff <= 1'b0;
         if (!first_ff) begin
            cnt_ff      <= cnt_ff - CNT_ONE;
            nack_seq_ff <= alu_sum[15:0];
         end
      end
   end

   // Tracker update in DIST, indexed by the live classification
   always_ff @(posedge clock) begin
      if (reset) begin
         latest_seq_ff[0] <= '0;
         latest_seq_ff[1] <= '0;
         seq_seen_ff      <= '0;
      end else if (state_ff == S_DIST && is_media &&
                   (!seq_seen_ff[dist_stream] || advance_in)) begin
         latest_seq_ff[dist_stream] <= seq_ff;
         seq_seen_ff[dist_stream]   <= 1'b1;
      end
   end

   // Running totals, one per adder step
   always_ff @(posedge clock) begin
      if (reset) begin
         received_ff <= '0;
         lost_ff     <= '0;
         nacked_ff   <= '0;
      end else begin
         if (state_ff == S_RECV)   received_ff <= alu_sum;
         if (state_ff == S_LOST)   lost_ff     <= alu_sum;
         if (state_ff == S_NACKED) nacked_ff   <= alu_sum;
      end
   end

   // Result register: classification first, then NACKs in ascending order
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_received_ff <= received_ff;
         rsp_lost_ff     <= lost_ff;
         rsp_nacked_ff   <= nacked_ff;
         if (first_ff) begin
            rsp_kind_ff     <= kind_ff;
            rsp_nack_seq_ff <= '0;
            rsp_ssrc_ff     <= '0;
            rsp_len_bad_ff  <= len_bad_ff;
            rsp_last_ff     <= (cnt_ff == CNT_ZERO);
         end else begin
            rsp_kind_ff     <= rtp_icn_pkg::K_NACK;
            rsp_nack_seq_ff <= alu_sum[15:0];
            rsp_ssrc_ff     <= stream_ff ? video_source_id_ff : audio_source_id_ff;
            rsp_len_bad_ff  <= 1'b0;
            rsp_last_ff     <= (cnt_ff == CNT_ONE);
         end
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.kind           = rsp_kind_ff;
   assign rsp_bus.nack_sequence  = rsp_nack_seq_ff;
   assign rsp_bus.nack_ssrc      = rsp_ssrc_ff;
   assign rsp_bus.last           = rsp_last_ff;
   assign rsp_bus.length_bad     = rsp_len_bad_ff;
   assign rsp_bus.received_count = rsp_received_ff;
   assign rsp_bus.lost_count     = rsp_lost_ff;
   assign rsp_bus.nacked_count   = rsp_nacked_ff;

   // Checks on the sequencer
   a_accept_to_dist: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_DIST)
      else $error("accepted header did not enter the difference step");

   a_run_capped: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("NACK run count above the cap");

   a_lost_needs_advance: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOST |-> advance_ff)
      else $error("lost total updated without a forward jump");

   a_nack_after_first: assert property (@(posedge clock) disable iff (reset)
      rsp_load && !first_ff |=> rsp_kind_ff == rtp_icn_pkg::K_NACK && rsp_valid_ff)
      else $error("follow-on result is not a NACK");

endmodule

[tb/tb_rtp_ingest_classify_and_nack.sv]
// Self-checking testbench for the RTP ingest classifier and NACK generator.
`timescale 1ns / 100ps

module tb_rtp_ingest_classify_and_nack;

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned SETTLE_CYCLES = 8;

   // Index beyond the register list; writes to it must be ignored
   localparam logic [rtp_icn_pkg::CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef enum {SET_RANDOM, SET_LOW, SET_HIGH} reg_setting_type;

   typedef struct {
      logic [31:0] source_addr;
      logic [10:0] packet_length;
      logic [6:0]  payload_type;
      logic        marker;
      logic [15:0] sequence_req;
   } header_type;

   typedef struct {
      rtp_icn_pkg::kind_type kind;
      logic [15:0]           nack_sequence;
      logic [31:0]           nack_ssrc;
      logic                  last;
      logic                  length_bad;
      logic [31:0]           received_count;
      logic [31:0]           lost_count;
      logic [31:0]           nacked_count;
   } result_type;

   logic clock = 1'b0;
   logic reset;
   logic                               csr_write_enable;
   logic [rtp_icn_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rtp_icn_pkg::CSR_DATA_W-1:0] csr_write_data;

   rtp_icn_req_if req_if ();
   rtp_icn_rsp_if rsp_if ();

   rtp_ingest_classify_and_nack dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register copy
   logic [31:0] cfg_accept_address = '0;
   logic [6:0]  cfg_audio_type     = rtp_icn_pkg::AUDIO_TYPE_RST;
   logic [6:0]  cfg_video_type     = rtp_icn_pkg::VIDEO_TYPE_RST;
   logic [31:0] cfg_audio_ssrc     = '0;
   logic [31:0] cfg_video_ssrc     = '0;
   logic [7:0]  cfg_ping_type      = rtp_icn_pkg::PING_TYPE_RST;
   logic [7:0]  cfg_report_type    = rtp_icn_pkg::REPORT_TYPE_RST;

   // Sequence tracker and totals, index 0 audio, index 1 video
   logic [15:0] latest_seq [2] = '{16'd0, 16'd0};
   logic        seq_seen   [2] = '{1'b0, 1'b0};
   logic [31:0] received_total = '0;
   logic [31:0] lost_total     = '0;
   logic [31:0] nacked_total   = '0;

   result_type due_results [$];
   int         error_count   = 0;
   int         send_idle_pct = 25;
   int         recv_idle_pct = 79;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rtp_ingest_classify_and_nack regression: fail");
      $finish;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, field, got, want);
      error_count++;
   endtask

   function automatic result_type make_result(input rtp_icn_pkg::kind_type kind,
                                              input logic [15:0] nack_seq,
                                              input logic [31:0] ssrc,
                                              input logic len_bad);
      result_type r;
      r.kind           = kind;
      r.nack_sequence  = nack_seq;
      r.nack_ssrc      = ssrc;
      r.last           = 1'b0;
      r.length_bad     = len_bad;
      r.received_count = '0;
      r.lost_count     = '0;
      r.nacked_count   = '0;
      return r;
   endfunction

   function automatic header_type make_header(input logic [31:0] src, input logic [10:0] len,
                                              input logic [7:0] full_type,
                                              input logic [15:0] seq);
      header_type h;
      h.source_addr   = src;
      h.packet_length = len;
      h.marker        = full_type[7];
      h.payload_type  = full_type[6:0];
      h.sequence_req  = seq;
      return h;
   endfunction

   // Classify one accepted header, update the tracker and queue its results
   function automatic void classify_header(input header_type h);
      result_type  batch [$];
      result_type  r;
      logic        stream;
      logic [31:0] ssrc;
      logic [15:0] seq_dist;
      logic [15:0] gap;
      logic [15:0] run;
      logic [7:0]  full_type;
      if (h.source_addr != cfg_accept_address) begin
         batch = {batch, make_result(rtp_icn_pkg::K_BADSRC, '0, '0, 1'b0)};
      end else if (h.packet_length < rtp_icn_pkg::MIN_RTP_LEN) begin
         batch = {batch, make_result(rtp_icn_pkg::K_SHORT, '0, '0, 1'b0)};
      end else if (h.payload_type == cfg_video_type || h.payload_type == cfg_audio_type) begin
         // video wins when both types match; marker plays no part
         stream = (h.payload_type == cfg_video_type) ? rtp_icn_pkg::STREAM_VIDEO
                                                     : rtp_icn_pkg::STREAM_AUDIO;
         ssrc   = (stream == rtp_icn_pkg::STREAM_VIDEO) ? cfg_video_ssrc : cfg_audio_ssrc;
         received_total++;
         batch = {batch, make_result((stream == rtp_icn_pkg::STREAM_VIDEO) ?
                                     rtp_icn_pkg::K_VIDEO : rtp_icn_pkg::K_AUDIO,
                                     '0, '0, 1'b0)};
         if (!seq_seen[stream]) begin
            seq_seen[stream]   = 1'b1;
            latest_seq[stream] = h.sequence_req;
         end else begin
            seq_dist = h.sequence_req - latest_seq[stream];
            // forward jump only: duplicates and older numbers leave the state alone
            if (seq_dist != 16'd0 && seq_dist < 16'h8000) begin
               gap = seq_dist - 16'd1;
               run = (gap < 16'(rtp_icn_pkg::MAX_NACK_RUN_DEF)) ? gap
                                                               : 16'(rtp_icn_pkg::MAX_NACK_RUN_DEF);
               lost_total += 32'(gap);
               for (int i = 1; i <= run; i++) begin
                  batch = {batch, make_result(rtp_icn_pkg::K_NACK,
                                              latest_seq[stream] + 16'(i), ssrc, 1'b0)};
                  nacked_total++;
               end
               latest_seq[stream] = h.sequence_req;
            end
         end
      end else begin
         full_type = {h.marker, h.payload_type};
         if (full_type == cfg_ping_type)
            batch = {batch, make_result(rtp_icn_pkg::K_PING, '0, '0, 1'b0)};
         else if (full_type == cfg_report_type)
            batch = {batch, make_result(rtp_icn_pkg::K_REPORT, '0, '0,
                                        h.packet_length != rtp_icn_pkg::REPORT_LEN)};
         else
            batch = {batch, make_result(rtp_icn_pkg::K_UNKNOWN, '0, '0, 1'b0)};
      end
      // totals are those after the whole header
      for (int i = 0; i < batch.size(); i++) begin
         r                = batch[i];
         r.last           = (i == batch.size() - 1);
         r.received_count = received_total;
         r.lost_count     = lost_total;
         r.nacked_count   = nacked_total;
         due_results      = {due_results, r};
      end
   endfunction

   // Offer one header and hold it until the transaction completes
   task automatic send_header(input header_type h);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.source_addr   <= h.source_addr;
      req_if.packet_length <= h.packet_length;
      req_if.payload_type  <= h.payload_type;
      req_if.marker        <= h.marker;
      req_if.sequence_req  <= h.sequence_req;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      classify_header(h);
   endtask

   // Stop sending and wait for every due result, then let the block settle
   task automatic await_idle();
      req_if.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [rtp_icn_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         rtp_icn_pkg::CSR_ACCEPT_ADDRESS:  cfg_accept_address = data;
         rtp_icn_pkg::CSR_AUDIO_TYPE:      cfg_audio_type     = data[6:0];
         rtp_icn_pkg::CSR_VIDEO_TYPE:      cfg_video_type     = data[6:0];
         rtp_icn_pkg::CSR_AUDIO_SOURCE_ID: cfg_audio_ssrc     = data;
         rtp_icn_pkg::CSR_VIDEO_SOURCE_ID: cfg_video_ssrc     = data;
         rtp_icn_pkg::CSR_PING_TYPE:       cfg_ping_type      = data[7:0];
         rtp_icn_pkg::CSR_REPORT_TYPE:     cfg_report_type    = data[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_registers(input reg_setting_type setting);
      logic [31:0] data [8];
      for (int i = 0; i < 8; i++)
         data[i] = (setting == SET_LOW) ? 32'd0 :
                   (setting == SET_HIGH) ? 32'hFFFF_FFFF : $urandom;
      write_reg(rtp_icn_pkg::CSR_ACCEPT_ADDRESS,  data[0]);
      write_reg(rtp_icn_pkg::CSR_AUDIO_TYPE,      data[1]);
      write_reg(rtp_icn_pkg::CSR_VIDEO_TYPE,      data[2]);
      write_reg(rtp_icn_pkg::CSR_AUDIO_SOURCE_ID, data[3]);
      write_reg(rtp_icn_pkg::CSR_VIDEO_SOURCE_ID, data[4]);
      write_reg(rtp_icn_pkg::CSR_PING_TYPE,       data[5]);
      write_reg(rtp_icn_pkg::CSR_REPORT_TYPE,     data[6]);
      write_reg(CSR_UNUSED_INDEX,                 data[7]);
   endtask

   // Mostly in-order media with random gaps, plus rejects and control packets
   task automatic run_random_chunk(input int count);
      header_type  h;
      int          pick;
      logic        stream;
      logic [15:0] step;
      logic [7:0]  full_type;
      for (int n = 0; n < count; n++) begin
         h.source_addr   = cfg_accept_address;
         h.packet_length = 11'($urandom_range(rtp_icn_pkg::MIN_RTP_LEN, 2047));
         h.marker        = 1'($urandom_range(1));
         h.payload_type  = 7'($urandom);
         h.sequence_req  = 16'($urandom);
         pick = $urandom_range(99);
         if (pick < 8) begin
            h.source_addr = $urandom;
            if (h.source_addr == cfg_accept_address)
               h.source_addr = h.source_addr ^ (32'd1 << $urandom_range(31));
         end else if (pick < 15) begin
            h.packet_length = 11'($urandom_range(rtp_icn_pkg::MIN_RTP_LEN - 1));
         end else if (pick < 75) begin
            stream = 1'($urandom_range(1));
            h.payload_type = (stream == rtp_icn_pkg::STREAM_VIDEO) ? cfg_video_type
                                                                   : cfg_audio_type;
            if (seq_seen[stream]) begin
               pick = $urandom_range(99);
               if (pick < 55)      step = 16'd1;
               else if (pick < 75) step = 16'($urandom_range(2, 6));
               else if (pick < 83) step = 16'd0;
               else if (pick < 90) step = 16'($urandom_range(16'h8000, 16'hFFFF));
               else if (pick < 96) step = 16'($urandom_range(7, 70));
               else                step = 16'($urandom_range(71, 16'h7FFF));
               h.sequence_req = latest_seq[stream] + step;
            end
         end else begin
            pick = $urandom_range(2);
            full_type = (pick == 0) ? cfg_ping_type :
                        (pick == 1) ? cfg_report_type : 8'($urandom);
            {h.marker, h.payload_type} = full_type;
            if (full_type == cfg_report_type && $urandom_range(1))
               h.packet_length = rtp_icn_pkg::REPORT_LEN;
         end
         send_header(h);
      end
   endtask

   // Source filter and minimum length, at reset settings
   task automatic test_source_and_length();
      send_header(make_header(32'hFFFF_FFFF, 11'd2047, 8'h00, 16'hFFFF));
      send_header(make_header(32'd0, 11'd0, 8'hFF, 16'd0));
      send_header(make_header(32'd0, rtp_icn_pkg::MIN_RTP_LEN - 11'd1, 8'h00, 16'd0));
      send_header(make_header(32'd0, rtp_icn_pkg::MIN_RTP_LEN, 8'h00, 16'd0));
   endtask

   // Ping, sender report of good and bad length, unknown type
   task automatic test_control_types();
      send_header(make_header(32'd0, rtp_icn_pkg::MIN_RTP_LEN, rtp_icn_pkg::PING_TYPE_RST,
                              16'd0));
      send_header(make_header(32'd0, rtp_icn_pkg::REPORT_LEN, rtp_icn_pkg::REPORT_TYPE_RST,
                              16'd0));
      send_header(make_header(32'd0, 11'd2047, rtp_icn_pkg::REPORT_TYPE_RST, 16'd0));
      send_header(make_header(32'd0, rtp_icn_pkg::MIN_RTP_LEN, 8'hFF, 16'd0));
   endtask

   // First packet, in order across the wrap, duplicate, old packet, marker on media
   task automatic test_sequence_tracking();
      send_header(make_header(32'd0, 11'd100, {1'b0, rtp_icn_pkg::AUDIO_TYPE_RST}, 16'hFFFE));
      send_header(make_header(32'd0, 11'd100, {1'b0, rtp_icn_pkg::AUDIO_TYPE_RST}, 16'hFFFF));
      send_header(make_header(32'd0, 11'd100, {1'b1, rtp_icn_pkg::AUDIO_TYPE_RST}, 16'h0002));
      send_header(make_header(32'd0, 11'd100, {1'b0, rtp_icn_pkg::AUDIO_TYPE_RST}, 16'h0002));
      send_header(make_header(32'd0, 11'd100, {1'b0, rtp_icn_pkg::AUDIO_TYPE_RST}, 16'h8002));
      send_header(make_header(32'd0, 11'd100, {1'b1, rtp_icn_pkg::VIDEO_TYPE_RST}, 16'd100));
      send_header(make_header(32'd0, 11'd100, {1'b0, rtp_icn_pkg::VIDEO_TYPE_RST}, 16'd104));
   endtask

   // Gaps past the NACK cap, up to the largest forward distance
   task automatic test_long_gaps();
      send_header(make_header(32'd0, 11'd1200, {1'b0, rtp_icn_pkg::VIDEO_TYPE_RST}, 16'd304));
      send_header(make_header(32'd0, 11'd1200, {1'b0, rtp_icn_pkg::VIDEO_TYPE_RST}, 16'd369));
      send_header(make_header(32'd0, 11'd1200, {1'b0, rtp_icn_pkg::VIDEO_TYPE_RST},
                              16'd369 + 16'h7FFF));
   endtask

   // Every register with oversized values, matching media types, unused index
   task automatic test_register_writes();
      await_idle();
      write_reg(rtp_icn_pkg::CSR_ACCEPT_ADDRESS,  32'hFFFF_FFFF);
      write_reg(rtp_icn_pkg::CSR_AUDIO_TYPE,      32'hFFFF_FF80);
      write_reg(rtp_icn_pkg::CSR_VIDEO_TYPE,      32'd0);
      write_reg(rtp_icn_pkg::CSR_AUDIO_SOURCE_ID, 32'hFFFF_FFFF);
      write_reg(rtp_icn_pkg::CSR_VIDEO_SOURCE_ID, 32'h8000_0001);
      write_reg(rtp_icn_pkg::CSR_PING_TYPE,       32'hFFFF_FFFF);
      write_reg(rtp_icn_pkg::CSR_REPORT_TYPE,     32'h0000_0100);
      write_reg(CSR_UNUSED_INDEX,                 32'hFFFF_FFFF);
      send_header(make_header(32'hFFFF_FFFF, rtp_icn_pkg::MIN_RTP_LEN, 8'h80,
                              latest_seq[rtp_icn_pkg::STREAM_VIDEO] + 16'd2));
      send_header(make_header(32'hFFFF_FFFF, rtp_icn_pkg::MIN_RTP_LEN, 8'hFF, 16'd0));
      send_header(make_header(32'hFFFF_FFFF, rtp_icn_pkg::MIN_RTP_LEN, 8'h7F, 16'd0));
      send_header(make_header(32'd0, rtp_icn_pkg::MIN_RTP_LEN, 8'h7F, 16'd0));
   endtask

   // Three idle plans, each over random and extreme register settings
   task automatic test_random_traffic();
      int idle_plan [3][2] = '{'{25, 79}, '{79, 25}, '{0, 0}};
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = idle_plan[p][0];
         recv_idle_pct = idle_plan[p][1];
         await_idle();
         load_registers(SET_RANDOM);
         run_random_chunk(50);
         await_idle();
         load_registers((p == 1) ? SET_HIGH : SET_LOW);
         run_random_chunk(50);
         await_idle();
         load_registers(SET_RANDOM);
         run_random_chunk(50);
      end
   endtask

   // Result channel back-pressure
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each result transaction with the oldest one due
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (due_results.size() == 0) begin
            report_mismatch("result with nothing due, kind", 32'(rsp_if.kind), '0);
         end else begin
            want = due_results.pop_front();
            if (rsp_if.kind !== want.kind)
               report_mismatch("kind", 32'(rsp_if.kind), 32'(want.kind));
            if (rsp_if.nack_sequence !== want.nack_sequence)
               report_mismatch("nack_sequence", 32'(rsp_if.nack_sequence),
                               32'(want.nack_sequence));
            if (rsp_if.nack_ssrc !== want.nack_ssrc)
               report_mismatch("nack_ssrc", rsp_if.nack_ssrc, want.nack_ssrc);
            if (rsp_if.last !== want.last)
               report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
            if (rsp_if.length_bad !== want.length_bad)
               report_mismatch("length_bad", 32'(rsp_if.length_bad), 32'(want.length_bad));
            if (rsp_if.received_count !== want.received_count)
               report_mismatch("received_count", rsp_if.received_count, want.received_count);
            if (rsp_if.lost_count !== want.lost_count)
               report_mismatch("lost_count", rsp_if.lost_count, want.lost_count);
            if (rsp_if.nacked_count !== want.nacked_count)
               report_mismatch("nacked_count", rsp_if.nacked_count, want.nacked_count);
         end
      end
   end

   initial begin
      reset                <= 1'b1;
      csr_write_enable     <= 1'b0;
      csr_index            <= '0;
      csr_write_data       <= '0;
      req_if.valid         <= 1'b0;
      req_if.source_addr   <= '0;
      req_if.packet_length <= '0;
      req_if.payload_type  <= '0;
      req_if.marker        <= 1'b0;
      req_if.sequence_req  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_source_and_length();
      test_control_types();
      test_sequence_tracking();
      test_long_gaps();
      test_register_writes();
      test_random_traffic();

      await_idle();
      if (error_count == 0)
         $display("rtp_ingest_classify_and_nack regression: pass");
      else
         $display("rtp_ingest_classify_and_nack regression: fail");
      $finish;
   end

endmodule
